### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mpps_pkg.sv
package mpps_pkg;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_ON          = 3'd1,
    OP_OFF         = 3'd2,
    OP_PLAY        = 3'd3,
    OP_STOP        = 3'd4,
    OP_READY       = 3'd5,
    OP_READY_NO_OR = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    M_OFF        = 3'd0,
    M_INIT       = 3'd1,
    M_READY      = 3'd2,
    M_READY_PLAY = 3'd3,
    M_PLAY       = 3'd4,
    M_END        = 3'd5
  } main_mode_t;

  typedef enum logic [3:0] {
    S_OFF          = 4'd0,
    S_START_MOTION = 4'd1,
    S_INIT         = 4'd2,
    S_START        = 4'd3,
    S_ORIGIN       = 4'd4,
    S_ORIGIN_STOP  = 4'd5,
    S_STOP_READY   = 4'd6,
    S_READY        = 4'd7,
    S_LOAD         = 4'd8,
    S_PLAYING      = 4'd9,
    S_END          = 4'd10,
    S_END_STOP     = 4'd11,
    S_RESTART      = 4'd12,
    S_STOP_MOTION  = 4'd13,
    S_STOP         = 4'd14,
    S_DELAY        = 4'd15
  } sub_mode_t;

  typedef enum logic [1:0] {
    CMD_SERVO_ON  = 2'd0,
    CMD_START     = 2'd1,
    CMD_STOP      = 2'd2,
    CMD_SERVO_OFF = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_SERVO_ON_WAIT    = 3'd0,
    REG_STOP_SETTLE_WAIT = 3'd1,
    REG_SHORT_WAIT       = 3'd2,
    REG_RETURN_WAIT      = 3'd3,
    REG_SERVO_OFF_WAIT   = 3'd4
  } reg_index_t;

  localparam int unsigned TimeW = 16;
  localparam int unsigned WaitW = 18;
  localparam int unsigned PlayW = 32;

  localparam logic [TimeW-1:0] ServoOnWaitReset    = 16'd1000;
  localparam logic [TimeW-1:0] StopSettleWaitReset = 16'd3000;
  localparam logic [TimeW-1:0] ShortWaitReset      = 16'd100;
  localparam logic [TimeW-1:0] ReturnWaitReset     = 16'd1000;
  localparam logic [TimeW-1:0] ServoOffWaitReset   = 16'd1000;

endpackage

### rtl/motion_platform_power_sequencer.sv
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | op, elapsed_ms
// output   | out_valid / out_ready | command_valid, command_code, main_state,
//          |                       | detail_state, play_accepted, play_time_ms
// config   | cfg_write             | cfg_index, cfg_data
// A request is held in the input register, and its result is loaded into the result
// register when the output side can take it; the result is offered from there.
// One request is accepted in every cycle while the output side keeps taking results.
// A stalled result holds the result register, and the input register then fills.
// Synchronous reset returns the sequence to off with cleared play time and loads
// the default wait times.
module motion_platform_power_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                op,
  input  logic [15:0]               elapsed_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      command_valid,
  output logic [1:0]                command_code,
  output logic [2:0]                main_state,
  output logic [3:0]                detail_state,
  output logic                      play_accepted,
  output logic [31:0]               play_time_ms,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [15:0]               cfg_data
);
  import mpps_pkg::*;

  logic [TimeW-1:0] servo_on_wait;
  logic [TimeW-1:0] stop_settle_wait;
  logic [TimeW-1:0] short_wait;
  logic [TimeW-1:0] return_wait;
  logic [TimeW-1:0] servo_off_wait;

  logic             req_valid;
  logic [2:0]       req_op;
  logic [TimeW-1:0] req_elapsed;

  main_mode_t       main_mode, main_next;
  sub_mode_t        sub_mode, sub_next;
  logic [WaitW-1:0] wait_remaining, wait_next;
  sub_mode_t        after_wait, after_next;
  logic [PlayW-1:0] play_total, play_next;
  logic             cmd_valid_next;
  cmd_code_t        cmd_code_next;
  logic             accepted_next;
  logic [PlayW:0]   play_sum;
  logic             advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;
  assign play_sum = {1'b0, play_total} + {{(PlayW-TimeW+1){1'b0}}, req_elapsed};

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_on_wait    <= ServoOnWaitReset;
      stop_settle_wait <= StopSettleWaitReset;
      short_wait       <= ShortWaitReset;
      return_wait      <= ReturnWaitReset;
      servo_off_wait   <= ServoOffWaitReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SERVO_ON_WAIT:    servo_on_wait    <= cfg_data;
        REG_STOP_SETTLE_WAIT: stop_settle_wait <= cfg_data;
        REG_SHORT_WAIT:       short_wait       <= cfg_data;
        REG_RETURN_WAIT:      return_wait      <= cfg_data;
        REG_SERVO_OFF_WAIT:   servo_off_wait   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    main_next      = main_mode;
    sub_next       = sub_mode;
    wait_next      = wait_remaining;
    after_next     = after_wait;
    play_next      = play_total;
    cmd_valid_next = 1'b0;
    cmd_code_next  = CMD_SERVO_ON;
    accepted_next  = 1'b0;
    case (req_op)
      OP_TICK: begin
        case (sub_mode)
          S_OFF: main_next = M_OFF;
          S_START_MOTION: sub_next = S_INIT;
          S_INIT: begin
            cmd_valid_next = 1'b1;
            cmd_code_next  = CMD_SERVO_ON;
            sub_next       = S_DELAY;
            wait_next      = {2'b00, servo_on_wait};
            after_next     = S_STOP_READY;
          end
          S_START: begin
            main_next      = M_READY_PLAY;
            cmd_valid_next = 1'b1;
            cmd_code_next  = CMD_START;
            sub_next       = S_DELAY;
            wait_next      = {2'b00, short_wait};
            after_next     = S_PLAYING;
          end
          S_ORIGIN: begin
            sub_next   = S_DELAY;
            wait_next  = '0;
            after_next = S_READY;
          end
          S_ORIGIN_STOP: begin
            sub_next   = S_DELAY;
            wait_next  = {2'b00, return_wait};
            after_next = S_STOP_READY;
          end
          S_STOP_READY: begin
            cmd_valid_next = 1'b1;
            cmd_code_next  = CMD_STOP;
            sub_next       = S_DELAY;
            wait_next      = {2'b00, stop_settle_wait};
            after_next     = S_READY;
          end
          S_READY: main_next = M_READY;
          S_LOAD: begin
            sub_next   = S_DELAY;
            wait_next  = {2'b00, short_wait};
            after_next = S_START;
          end
          S_PLAYING: begin
            main_next = M_PLAY;
            play_next = play_sum[PlayW] ? '1 : play_sum[PlayW-1:0];
          end
          S_END: begin
            sub_next   = S_DELAY;
            wait_next  = {2'b00, return_wait};
            after_next = S_END_STOP;
          end
          S_END_STOP: begin
            cmd_valid_next = 1'b1;
            cmd_code_next  = CMD_STOP;
            sub_next       = S_DELAY;
            wait_next      = {2'b00, stop_settle_wait};
            after_next     = S_STOP;
          end
          S_RESTART: ;
          S_STOP_MOTION: sub_next = S_END;
          S_STOP: begin
            cmd_valid_next = 1'b1;
            cmd_code_next  = CMD_SERVO_OFF;
            sub_next       = S_DELAY;
            wait_next      = {2'b00, servo_off_wait};
            after_next     = S_OFF;
          end
          S_DELAY: begin
            if ({2'b00, req_elapsed} > wait_remaining) begin
              sub_next = after_wait;
            end else begin
              wait_next = wait_remaining - {2'b00, req_elapsed};
            end
          end
          default: ;
        endcase
      end
      OP_ON: begin
        main_next = M_INIT;
        sub_next  = S_START_MOTION;
      end
      OP_OFF: begin
        main_next = M_END;
        sub_next  = S_STOP_MOTION;
      end
      OP_PLAY: begin
        case (main_mode)
          M_READY_PLAY: accepted_next = 1'b1;
          M_PLAY: begin
            accepted_next = 1'b1;
            if (sub_mode == S_DELAY) begin
              sub_next = S_START;
            end
          end
          M_READY: begin
            accepted_next = 1'b1;
            sub_next      = S_START;
          end
          default: ;
        endcase
      end
      OP_STOP: begin
        if (main_mode == M_READY_PLAY || main_mode == M_PLAY) begin
          sub_next  = S_ORIGIN_STOP;
          play_next = '0;
        end
      end
      OP_READY: begin
        sub_next  = S_ORIGIN_STOP;
        play_next = '0;
      end
      OP_READY_NO_OR: begin
        play_next  = '0;
        sub_next   = S_DELAY;
        wait_next  = {2'b00, short_wait};
        after_next = S_STOP_READY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_ready) begin
      req_op      <= op;
      req_elapsed <= elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_mode      <= M_OFF;
      sub_mode       <= S_OFF;
      wait_remaining <= '0;
      after_wait     <= S_OFF;
      play_total     <= '0;
      out_valid      <= 1'b0;
    end else if (req_valid && advance) begin
      main_mode      <= main_next;
      sub_mode       <= sub_next;
      wait_remaining <= wait_next;
      after_wait     <= after_next;
      play_total     <= play_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (req_valid && advance) begin
      command_valid <= cmd_valid_next;
      command_code  <= cmd_valid_next ? cmd_code_next : CMD_SERVO_ON;
      main_state    <= main_next;
      detail_state  <= sub_next;
      play_accepted <= accepted_next;
      play_time_ms  <= play_next;
    end
  end

endmodule

### rtl/mpps_checker.sv
`include "assert_macros.svh"

module mpps_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        command_valid,
  input logic [1:0]  command_code,
  input logic [2:0]  main_state,
  input logic [3:0]  detail_state,
  input logic [31:0] play_time_ms
);
  import mpps_pkg::*;

  // A result that is not taken stays in place.
  `ASSERT_RUN(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(detail_state) && $stable(play_time_ms), "stalled result changed")

  // Every platform command opens a timed wait.
  `ASSERT_RUN(a_cmd_waits, clk, rst, out_valid && command_valid |-> detail_state == S_DELAY, "command issued without a wait")

  // The start command is only issued on entry to ready play.
  `ASSERT_RUN(a_start_mode, clk, rst, out_valid && command_valid && command_code == CMD_START |-> main_state == M_READY_PLAY, "start outside ready play")

  // No result is offered in the cycle after reset.
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result present after reset")

endmodule

bind motion_platform_power_sequencer mpps_checker u_mpps_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .command_valid (command_valid),
  .command_code  (command_code),
  .main_state    (main_state),
  .detail_state  (detail_state),
  .play_time_ms  (play_time_ms)
);

### test/motion_platform_power_sequencer_tb.sv
module motion_platform_power_sequencer_tb;
  import mpps_pkg::*;

  typedef struct packed {
    logic       command_valid;
    cmd_code_t  command_code;
    main_mode_t main_state;
    sub_mode_t  detail_state;
    logic       play_accepted;
    logic [31:0] play_time_ms;
  } result_t;

  typedef struct packed {
    logic [2:0] op;
    logic [15:0] el;
    logic       typed;
    result_t    want;
  } row_t;

  localparam logic [2:0] OpUnused = 3'd7;
  localparam cmd_code_t NoCmd = CMD_SERVO_ON;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomPerPhase = 120;
  localparam int unsigned PlayTicks = 40;

  localparam row_t Script [27] = '{
    '{OP_TICK, 16'd0, 1'b1, '{1'b0, NoCmd, M_OFF, S_OFF, 1'b0, 32'd0}},
    '{OpUnused, 16'hFFFF, 1'b1, '{1'b0, NoCmd, M_OFF, S_OFF, 1'b0, 32'd0}},
    '{OP_PLAY, 16'd0, 1'b1, '{1'b0, NoCmd, M_OFF, S_OFF, 1'b0, 32'd0}},
    '{OP_STOP, 16'hFFFF, 1'b1, '{1'b0, NoCmd, M_OFF, S_OFF, 1'b0, 32'd0}},
    '{OP_ON, 16'hFFFF, 1'b1, '{1'b0, NoCmd, M_INIT, S_START_MOTION, 1'b0, 32'd0}},
    '{OP_TICK, 16'd0, 1'b1, '{1'b0, NoCmd, M_INIT, S_INIT, 1'b0, 32'd0}},
    '{OP_TICK, 16'd0, 1'b1, '{1'b1, CMD_SERVO_ON, M_INIT, S_DELAY, 1'b0, 32'd0}},
    '{OP_TICK, 16'd1000, 1'b0, '0},
    '{OP_TICK, 16'd1, 1'b0, '0},
    '{OP_TICK, 16'd0, 1'b0, '0},
    '{OP_TICK, 16'hFFFF, 1'b0, '0},
    '{OP_TICK, 16'd0, 1'b0, '0},
    '{OP_PLAY, 16'd0, 1'b0, '0},
    '{OP_TICK, 16'd0, 1'b0, '0},
    '{OP_PLAY, 16'd0, 1'b0, '0},
    '{OP_TICK, 16'hFFFF, 1'b0, '0},
    '{OP_TICK, 16'hFFFF, 1'b0, '0},
    '{OP_TICK, 16'd1, 1'b0, '0},
    '{OP_PLAY, 16'd0, 1'b0, '0},
    '{OP_STOP, 16'd0, 1'b0, '0},
    '{OP_TICK, 16'd0, 1'b0, '0},
    '{OP_PLAY, 16'd0, 1'b0, '0},
    '{OP_READY_NO_OR, 16'hFFFF, 1'b0, '0},
    '{OP_READY, 16'd0, 1'b0, '0},
    '{OP_OFF, 16'd0, 1'b0, '0},
    '{OP_PLAY, 16'd0, 1'b1, '{1'b0, NoCmd, M_END, S_STOP_MOTION, 1'b0, 32'd0}},
    '{OP_TICK, 16'd0, 1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [15:0] elapsed_ms;
  logic        out_valid;
  logic        out_ready;
  logic        command_valid;
  logic [1:0]  command_code;
  logic [2:0]  main_state;
  logic [3:0]  detail_state;
  logic        play_accepted;
  logic [31:0] play_time_ms;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  main_mode_t  mode_now;
  sub_mode_t   step_now;
  sub_mode_t   step_after_wait;
  logic [17:0] wait_left;
  logic [31:0] play_total;
  logic [15:0] wait_cfg [5];
  logic [15:0] next_waits [5];

  result_t     outstanding_results [$];
  result_t     oldest;
  bit          calm;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned cycle_count;

  motion_platform_power_sequencer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .command_valid(command_valid), .command_code(command_code),
    .main_state(main_state), .detail_state(detail_state),
    .play_accepted(play_accepted), .play_time_ms(play_time_ms),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void start_wait(input logic [15:0] ms, input sub_mode_t follow_on);
    step_now = S_DELAY;
    wait_left = 18'(ms);
    step_after_wait = follow_on;
  endfunction

  function automatic result_t sequence_request(input logic [2:0] req_op,
                                               input logic [15:0] el);
    result_t res;
    res = '0;
    case (req_op)
      OP_TICK: begin
        case (step_now)
          S_OFF: mode_now = M_OFF;
          S_START_MOTION: step_now = S_INIT;
          S_INIT: begin
            res.command_valid = 1'b1;
            res.command_code = CMD_SERVO_ON;
            start_wait(wait_cfg[REG_SERVO_ON_WAIT], S_STOP_READY);
          end
          S_START: begin
            mode_now = M_READY_PLAY;
            res.command_valid = 1'b1;
            res.command_code = CMD_START;
            start_wait(wait_cfg[REG_SHORT_WAIT], S_PLAYING);
          end
          S_ORIGIN: start_wait('0, S_READY);
          S_ORIGIN_STOP: start_wait(wait_cfg[REG_RETURN_WAIT], S_STOP_READY);
          S_STOP_READY: begin
            res.command_valid = 1'b1;
            res.command_code = CMD_STOP;
            start_wait(wait_cfg[REG_STOP_SETTLE_WAIT], S_READY);
          end
          S_READY: mode_now = M_READY;
          S_LOAD: start_wait(wait_cfg[REG_SHORT_WAIT], S_START);
          S_PLAYING: begin
            mode_now = M_PLAY;
            if (play_total > 32'hFFFF_FFFF - 32'(el)) play_total = 32'hFFFF_FFFF;
            else play_total = play_total + 32'(el);
          end
          S_END: start_wait(wait_cfg[REG_RETURN_WAIT], S_END_STOP);
          S_END_STOP: begin
            res.command_valid = 1'b1;
            res.command_code = CMD_STOP;
            start_wait(wait_cfg[REG_STOP_SETTLE_WAIT], S_STOP);
          end
          S_RESTART: ;
          S_STOP_MOTION: step_now = S_END;
          S_STOP: begin
            res.command_valid = 1'b1;
            res.command_code = CMD_SERVO_OFF;
            start_wait(wait_cfg[REG_SERVO_OFF_WAIT], S_OFF);
          end
          default: begin
            if (18'(el) > wait_left) step_now = step_after_wait;
            else wait_left = wait_left - 18'(el);
          end
        endcase
      end
      OP_ON: begin
        mode_now = M_INIT;
        step_now = S_START_MOTION;
      end
      OP_OFF: begin
        mode_now = M_END;
        step_now = S_STOP_MOTION;
      end
      OP_PLAY: begin
        case (mode_now)
          M_READY_PLAY: res.play_accepted = 1'b1;
          M_PLAY: begin
            if (step_now == S_DELAY) step_now = S_START;
            res.play_accepted = 1'b1;
          end
          M_READY: begin
            step_now = S_START;
            res.play_accepted = 1'b1;
          end
          default: res.play_accepted = 1'b0;
        endcase
      end
      OP_STOP: begin
        if (mode_now == M_READY_PLAY || mode_now == M_PLAY) begin
          step_now = S_ORIGIN_STOP;
          play_total = '0;
        end
      end
      OP_READY: begin
        step_now = S_ORIGIN_STOP;
        play_total = '0;
      end
      OP_READY_NO_OR: begin
        play_total = '0;
        start_wait(wait_cfg[REG_SHORT_WAIT], S_STOP_READY);
      end
      default: ;
    endcase
    res.main_state = mode_now;
    res.detail_state = step_now;
    res.play_time_ms = play_total;
    return res;
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 3'($urandom_range(7));
    case (mode_now)
      M_OFF: return (r < 45) ? OP_ON : OP_TICK;
      M_READY: return (r < 50) ? OP_PLAY : (r < 56) ? OP_STOP : OP_TICK;
      M_READY_PLAY, M_PLAY: begin
        if (r < 10) return OP_STOP;
        if (r < 13) return OP_OFF;
        if (r < 16) return OP_READY;
        if (r < 19) return OP_READY_NO_OR;
        if (r < 25) return OP_PLAY;
        return OP_TICK;
      end
      default: begin
        if (r < 10) return OP_PLAY;
        if (r < 13) return OP_READY_NO_OR;
        if (r < 15) return OP_READY;
        if (r < 17) return (mode_now == M_INIT) ? OP_OFF : OP_ON;
        if (r < 19) return OP_STOP;
        return OP_TICK;
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'($urandom_range(300));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // The valid line is left high on return so that a following request can
  // be presented in the same cycle without a second assignment.
  task automatic send_request(input logic [2:0] req_op, input logic [15:0] el,
                              input logic typed, input result_t want);
    result_t forecast;
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    elapsed_ms <= el;
    do @(posedge clk); while (!in_ready);
    forecast = sequence_request(req_op, el);
    outstanding_results.push_back(typed ? want : forecast);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_waits();
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= (i <= int'(REG_SERVO_OFF_WAIT)) ? next_waits[i] : 16'($urandom);
      @(posedge clk);
      if (i <= int'(REG_SERVO_OFF_WAIT)) wait_cfg[i] = next_waits[i];
    end
    cfg_write <= 1'b0;
  endtask

  task automatic drive_to_play();
    int guard;
    guard = 0;
    while (!(mode_now == M_PLAY && step_now == S_PLAYING) && guard < 200) begin
      if (mode_now == M_OFF || mode_now == M_END) send_request(OP_ON, 16'd0, 1'b0, '0);
      else if (mode_now == M_READY) send_request(OP_PLAY, 16'd0, 1'b0, '0);
      else send_request(OP_TICK, 16'hFFFF, 1'b0, '0);
      guard++;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (outstanding_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        oldest = outstanding_results.pop_front();
        compare_field("command_valid", 32'(oldest.command_valid), 32'(command_valid));
        compare_field("command_code", 32'(oldest.command_code), 32'(command_code));
        compare_field("main_state", 32'(oldest.main_state), 32'(main_state));
        compare_field("detail_state", 32'(oldest.detail_state), 32'(detail_state));
        compare_field("play_accepted", 32'(oldest.play_accepted), 32'(play_accepted));
        compare_field("play_time_ms", oldest.play_time_ms, play_time_ms);
        results_checked++;
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_TICK;
    elapsed_ms = '0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_SERVO_ON_WAIT;
    cfg_data = '0;
    calm = 1'b0;
    mismatches = 0;
    requests_sent = 0;
    results_checked = 0;
    cycle_count = 0;
    mode_now = M_OFF;
    step_now = S_OFF;
    step_after_wait = S_OFF;
    wait_left = '0;
    play_total = '0;
    wait_cfg[REG_SERVO_ON_WAIT] = ServoOnWaitReset;
    wait_cfg[REG_STOP_SETTLE_WAIT] = StopSettleWaitReset;
    wait_cfg[REG_SHORT_WAIT] = ShortWaitReset;
    wait_cfg[REG_RETURN_WAIT] = ReturnWaitReset;
    wait_cfg[REG_SERVO_OFF_WAIT] = ServoOffWaitReset;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (Script[i]) send_request(Script[i].op, Script[i].el, Script[i].typed, Script[i].want);
    drain();

    // With every wait at zero the platform reaches play quickly, and a run of
    // long ticks then builds up the accumulated play time.
    foreach (next_waits[i]) next_waits[i] = '0;
    write_waits();
    calm = 1'b1;
    drive_to_play();
    repeat (PlayTicks) send_request(OP_TICK, 16'hFFFF, 1'b0, '0);
    send_request(OP_PLAY, 16'd0, 1'b0, '0);
    send_request(OP_READY, 16'd0, 1'b0, '0);
    calm = 1'b0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      foreach (next_waits[i]) begin
        case (phase)
          0: next_waits[i] = '0;
          1: next_waits[i] = 16'hFFFF;
          2: next_waits[i] = 16'($urandom_range(65535));
          3: next_waits[i] = 16'($urandom_range(300));
          4: next_waits[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: next_waits[i] = '0;
        endcase
      end
      if (phase == 5) begin
        next_waits[REG_SERVO_ON_WAIT] = ServoOnWaitReset;
        next_waits[REG_STOP_SETTLE_WAIT] = StopSettleWaitReset;
        next_waits[REG_SHORT_WAIT] = ShortWaitReset;
        next_waits[REG_RETURN_WAIT] = ReturnWaitReset;
        next_waits[REG_SERVO_OFF_WAIT] = ServoOffWaitReset;
      end
      write_waits();
      calm = (phase == 2);
      repeat (RandomPerPhase) send_request(pick_op(), pick_elapsed(), 1'b0, '0);
      drain();
    end
    calm = 1'b0;

    $display("Checked %0d results from %0d requests: directed sequencing, a long play",
             results_checked, requests_sent);
    $display("run and random sequences under six wait settings, extremes included.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
